>>> rtl/core/sha256_pkg.sv
// sha256_pkg: constants and round functions for the streaming sha-256 core
// no dependencies
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int WordW = 32;
  localparam int CntW  = 61;

  typedef logic [WordW-1:0] word_t;

  // controller to datapath commands
  typedef struct packed {
    logic       put_byte;     // write byte into buffer at position
    logic       put_pad;      // write 0x80 at position and clear rest
    logic       put_len;      // write bit length into words 14 and 15
    logic       clr_buf;      // clear whole buffer
    logic       start_blk;    // load working vars from chain value
    logic       do_round;     // run one round
    logic       finish_blk;   // add working vars into chain value
    logic       reload;       // reload initial hash, clear count
    logic       shift_out;    // rotate chain value by one word for output
  } sha_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] pos;          // byte position in block
    logic [5:0] round;        // current round
  } sha_stat_t;

  localparam word_t PadByte = 32'h00000080;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t ror(input word_t v, input int s);
    return (v >> s) | (v << (WordW - s));
  endfunction

endpackage

>>> rtl/core/sha256_stream_hash_core.sv
// sha256_stream_hash_core: streaming sha-256 top level
// depends on sha256_pkg, sha256_ctrl, sha256_dp
//
//   channel | ports                                   | direction
//   input   | in_valid in_ready in_data_byte          | in
//           | in_byte_valid in_final_item             |
//   result  | out_valid out_ready out_digest_word     | out
//           | out_word_index out_last_word            |
//
// bytes are taken while idle; the 64th byte of a block starts the round loop
// (one round per cycle) and the chain update
// a final item adds a pad step, a length step and one or two
// compressions (two when the pad lands at byte 56 or later), then eight transfers
// reset is synchronous; the initial hash is loaded at once, no clearing pass
// the digest words wait in the chain register while out_ready is low
`timescale 1ns / 1ps
module sha256_stream_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256_pkg::sha_cmd_t  cmd;
  sha256_pkg::sha_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_valid(in_byte_valid), .final_item(in_final_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .word_index(out_word_index), .last_word(out_last_word),
    .stat(stat), .cmd(cmd)
  );

  sha256_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(in_data_byte),
    .stat(stat), .head_word(out_digest_word)
  );

  // no intake while the digest is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("intake during output");

  // word index advances after each transfer unless last
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("word index skipped");

  // after the last word the core takes input again
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> in_ready)
    else $error("no return to intake");

endmodule

>>> rtl/core/sha256_dp.sv
// sha256_dp: block buffer, message schedule, round unit and chain value
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::sha_cmd_t  cmd,
  input  logic [7:0]            data_byte,
  output sha256_pkg::sha_stat_t stat,
  output sha256_pkg::word_t     head_word
);

  sha256_pkg::word_t buf_r [16];
  sha256_pkg::word_t w_r [16];
  sha256_pkg::word_t v_r [8];
  sha256_pkg::word_t h_r [8];
  logic [sha256_pkg::CntW-1:0] cnt_r;
  logic [5:0] round_r;

  logic [3:0] wi;
  logic [4:0] sh;
  logic [63:0] bits;
  sha256_pkg::word_t x15, x2, s0, s1, wnew, wcur, t1, t2;
  sha256_pkg::word_t bmask, bval;

  assign wi = cnt_r[5:2];
  assign sh = {~cnt_r[1:0], 3'b000};
  assign bits = {cnt_r, 3'b000};
  assign stat.pos = cnt_r[5:0];
  assign stat.round = round_r;
  assign head_word = h_r[0];

  // schedule word for this round
  always_comb begin
    x15 = w_r[4'(round_r - 6'd15)];
    x2  = w_r[4'(round_r - 6'd2)];
    s0 = sha256_pkg::ror(x15, 7) ^ sha256_pkg::ror(x15, 18) ^ (x15 >> 3);
    s1 = sha256_pkg::ror(x2, 17) ^ sha256_pkg::ror(x2, 19) ^ (x2 >> 10);
    wnew = w_r[round_r[3:0]] + s0 + w_r[4'(round_r - 6'd7)] + s1;
    wcur = (round_r < 6'd16) ? buf_r[round_r[3:0]] : wnew;
    t1 = v_r[7] + (sha256_pkg::ror(v_r[4], 6) ^ sha256_pkg::ror(v_r[4], 11)
         ^ sha256_pkg::ror(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + sha256_pkg::round_k(round_r) + wcur;
    t2 = (sha256_pkg::ror(v_r[0], 2) ^ sha256_pkg::ror(v_r[0], 13)
         ^ sha256_pkg::ror(v_r[0], 22))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // byte insert: keep higher bytes, clear lower ones
  always_comb begin
    bmask = (sh == 5'd24) ? '0 : (32'hffffffff << (sh + 5'd8));
    bval = cmd.put_pad ? sha256_pkg::PadByte : {24'd0, data_byte};
    bval = bval << sh;
  end

  // block buffer
  always_ff @(posedge clk) begin
    if (cmd.put_byte || cmd.put_pad) begin
      buf_r[wi] <= (buf_r[wi] & bmask) | bval;
    end
    for (int i = 0; i < 16; i++) begin
      if (cmd.clr_buf || (cmd.put_pad && 4'(i) > wi)) begin
        buf_r[i] <= '0;
      end
    end
    if (cmd.put_len) begin
      buf_r[14] <= bits[63:32];
      buf_r[15] <= bits[31:0];
    end
  end

  // schedule window and working vars
  always_ff @(posedge clk) begin
    if (cmd.start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.do_round) begin
      w_r[round_r[3:0]] <= wcur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // control registers: count, round, chain value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      round_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::init_h(3'(i));
    end else begin
      if (cmd.put_byte) cnt_r <= cnt_r + 1'b1;
      if (cmd.start_blk) round_r <= '0;
      else if (cmd.do_round) round_r <= round_r + 1'b1;
      if (cmd.finish_blk) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end else if (cmd.reload) begin
        cnt_r <= '0;
        for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::init_h(3'(i));
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) h_r[i] <= h_r[i+1];
        h_r[7] <= h_r[0];
      end
    end
  end

endmodule

>>> rtl/core/sha256_ctrl.sv
// sha256_ctrl: sequencer for byte intake, padding, rounds and digest output
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  byte_valid,
  input  logic                  final_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            word_index,
  output logic                  last_word,
  input  sha256_pkg::sha_stat_t stat,
  output sha256_pkg::sha_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RUN, S_FIN, S_PAD, S_PAD_RUN, S_LEN, S_LEN_RUN, S_LAST, S_OUT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic fin_r, fin_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign word_index = idx_r;
  assign last_word = (idx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    idx_nxt = idx_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          fin_nxt = final_item;
          if (byte_valid) begin
            cmd.put_byte = 1'b1;
            if (stat.pos == 6'd63) begin
              state_nxt = S_RUN;
            end else if (final_item) begin
              state_nxt = S_PAD;
            end
          end else if (final_item) begin
            state_nxt = S_PAD;
          end
          if (byte_valid && stat.pos == 6'd63) cmd.start_blk = 1'b1;
        end
      end
      // compress a full data block, the buffer is already final
      S_RUN: begin
        cmd.do_round = 1'b1;
        if (stat.round == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_blk = 1'b1;
        state_nxt = fin_r ? S_PAD : S_IDLE;
      end
      // pad byte; overflow into a second block when no room for length
      S_PAD: begin
        cmd.put_pad = 1'b1;
        if (stat.pos >= 6'd56) begin
          cmd.start_blk = 1'b1;
          state_nxt = S_PAD_RUN;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_PAD_RUN: begin
        cmd.do_round = 1'b1;
        if (stat.round == 6'd63) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish_blk = 1'b1;
        cmd.clr_buf = 1'b1;
        state_nxt = S_LEN;
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        cmd.start_blk = 1'b1;
        state_nxt = S_LEN_RUN;
      end
      S_LEN_RUN: begin
        cmd.do_round = 1'b1;
        if (stat.round == 6'd63) begin
          state_nxt = S_LAST;
        end
      end
      // fold the last block into the chain value before output
      S_LAST: begin
        cmd.finish_blk = 1'b1;
        idx_nxt = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.shift_out = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 3'd7) begin
            cmd.shift_out = 1'b0;
            cmd.reload = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule
